// File: rtl/fragment_reassembly_tracker_macros.svh
// ----------------------------------------------------------------------------
// Fragment reassembly tracker assertion macros
// Concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define FRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared constants, codes and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package frt_pkg;

    localparam int unsigned DEF_MAX_PAYLOAD = 1320;
    localparam int unsigned DEF_SLOTS       = 8;
    localparam int unsigned DEF_MAX_PIECES  = 4096;

    localparam logic [31:0] HDR_MAGIC   = 32'h5744_484d;
    localparam logic [15:0] HDR_VERSION = 16'd1;
    localparam logic [16:0] HDR_BYTES   = 17'd32;
    localparam logic [22:0] FRAME_LIMIT = 23'd4194304;
    localparam logic [31:0] DEF_TIMEOUT = 32'd250000;
    localparam int unsigned ROW_W       = 32;

    localparam logic REG_STALE_TIMEOUT = 1'b0;
    localparam logic REG_MAX_FRAME     = 1'b1;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_BAD_HDR  = 3'd3;
    localparam logic [2:0] ST_STALE_ID = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;
    localparam logic [2:0] ST_RANGE    = 3'd6;

    // serial number compare: a newer than b
    function automatic logic is_newer(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/frt_seen_mem.sv
// ----------------------------------------------------------------------------
// Fragment bitmap memory
// One row of fragment-seen bits per address, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_seen_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [AW-1:0]                  addr,
    input  wire logic [frt_pkg::ROW_W-1:0]      wdata,
    output logic      [frt_pkg::ROW_W-1:0]      rdata
);

    logic [frt_pkg::ROW_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: rtl/frt_age_cmp.sv
// ----------------------------------------------------------------------------
// Fragment reassembly age compare unit
// Wrapping age of a slot and compare against a bound.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_age_cmp (
    input  wire logic [63:0] now,
    input  wire logic [63:0] stamp,
    input  wire logic [63:0] bound,
    output logic      [63:0] age,
    output logic             over
);

    assign age  = now - stamp;
    assign over = age > bound;

endmodule

`default_nettype wire

// File: rtl/fragment_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Header check, slot lookup, bitmap update, purge and aging under a sequencer.
// ----------------------------------------------------------------------------
// A bad header or stale id ends after the header check, an attribute mismatch
// after the slot scan, an out-of-range piece after the offset multiply; else the
// bitmap update is followed by a purge or aging walk. A new frame first gets a
// slot and clears ceil(piece_total/32) bitmap rows. One transaction at a time;
// busy stays high meanwhile. Slot walks visit one slot per cycle.
// Reset: all slots free, counters clear, registers at defaults, no sweep.
// Results come as a one-cycle result_valid pulse; the receiver cannot stall.
`default_nettype none

`include "fragment_reassembly_tracker_macros.svh"

module fragment_reassembly_tracker #(
    parameter int unsigned MAX_PAYLOAD = frt_pkg::DEF_MAX_PAYLOAD,
    parameter int unsigned SLOTS       = frt_pkg::DEF_SLOTS,
    parameter int unsigned MAX_PIECES  = frt_pkg::DEF_MAX_PIECES,
    localparam int unsigned SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [31:0]       hdr_magic,
    input  wire logic [15:0]       hdr_version,
    input  wire logic [15:0]       hdr_flags,
    input  wire logic [31:0]       frame_number,
    input  wire logic [15:0]       piece_index,
    input  wire logic [15:0]       piece_total,
    input  wire logic [15:0]       payload_bytes,
    input  wire logic [31:0]       total_bytes,
    input  wire logic [63:0]       capture_time,
    input  wire logic [15:0]       datagram_bytes,
    input  wire logic [63:0]       now_us,
    output logic                   result_valid,
    output logic [2:0]             status,
    output logic                   write_payload,
    output logic [SLOT_W-1:0]      write_slot,
    output logic [21:0]            write_offset,
    output logic [31:0]            done_frame_number,
    output logic [15:0]            done_flags,
    output logic [63:0]            done_time,
    output logic [22:0]            done_bytes,
    output logic [31:0]            dropped_total
);

    localparam int unsigned ROWS      = (MAX_PIECES + frt_pkg::ROW_W - 1) / frt_pkg::ROW_W;
    localparam int unsigned ROWS_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned MEM_DEPTH = SLOTS * ROWS;
    localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
    localparam int unsigned PW        = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned OFF_W     = 16 + PW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_ALLOC = 4'd4;
    localparam logic [3:0] S_CLEAR = 4'd5;
    localparam logic [3:0] S_ATTR  = 4'd6;
    localparam logic [3:0] S_MUL2  = 4'd7;
    localparam logic [3:0] S_RANGE = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_PURGE = 4'd10;
    localparam logic [3:0] S_AGE   = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [3:0]  state_reg, state_next;

    logic [31:0] timeout_reg;
    logic [22:0] max_frame_reg;

    logic [31:0] magic_reg, fnum_reg, tot_reg;
    logic [15:0] ver_reg, flags_reg, pidx_reg, ptot_reg, pay_reg, dgram_reg;
    logic [63:0] ctime_reg, now_reg;

    logic              slot_valid_reg [SLOTS];
    logic [31:0]       slot_fnum_reg  [SLOTS];
    logic [15:0]       slot_flags_reg [SLOTS];
    logic [15:0]       slot_ptot_reg  [SLOTS];
    logic [22:0]       slot_bytes_reg [SLOTS];
    logic [63:0]       slot_time_reg  [SLOTS];
    logic [63:0]       slot_lu_reg    [SLOTS];
    logic [15:0]       slot_got_reg   [SLOTS];

    logic [31:0] last_num_reg;
    logic        any_reg;
    logic [31:0] drop_reg;

    logic [SLOT_W-1:0] ptr_reg;
    logic [ROWS_W-1:0] clr_row_reg;
    logic [OFF_W-1:0]  prod_reg;
    logic              found_reg, have_free_reg;
    logic [SLOT_W-1:0] match_reg, free_idx_reg, old_idx_reg;
    logic [63:0]       best_reg;

    logic [2:0]        status_reg;
    logic              wr_reg;
    logic [SLOT_W-1:0] wslot_reg;
    logic [21:0]       woff_reg;
    logic [31:0]       dnum_reg;
    logic [15:0]       dflags_reg;
    logic [63:0]       dtime_reg;
    logic [22:0]       dbytes_reg;

    // shared multiplier
    logic [15:0]      mul_a;
    logic [OFF_W-1:0] mul_p;
    assign mul_a = (state_reg == S_MUL1) ? (ptot_reg - 16'd1) : pidx_reg;
    assign mul_p = OFF_W'(mul_a) * OFF_W'(MAX_PAYLOAD);

    // shared age compare
    logic [63:0] age, age_bound;
    logic        age_over;
    assign age_bound = (state_reg == S_SCAN) ? best_reg : {32'd0, timeout_reg};

    frt_age_cmp u_age (
        .now   (now_reg),
        .stamp (slot_lu_reg[ptr_reg]),
        .bound (age_bound),
        .age   (age),
        .over  (age_over)
    );

    // header check
    logic [22:0] limit;
    logic        bad_hdr, stale_id;
    assign limit = (max_frame_reg > frt_pkg::FRAME_LIMIT) ? frt_pkg::FRAME_LIMIT : max_frame_reg;
    assign bad_hdr = (magic_reg != frt_pkg::HDR_MAGIC) || (ver_reg != frt_pkg::HDR_VERSION)
                  || (ptot_reg == 16'd0) || (32'(ptot_reg) > 32'(MAX_PIECES))
                  || (pidx_reg >= ptot_reg) || (32'(pay_reg) > 32'(MAX_PAYLOAD))
                  || ({1'b0, dgram_reg} != (17'(pay_reg) + frt_pkg::HDR_BYTES))
                  || (tot_reg == 32'd0) || (tot_reg > 32'(limit))
                  || (32'(prod_reg) >= tot_reg);
    assign stale_id = any_reg && !frt_pkg::is_newer(fnum_reg, last_num_reg);

    // scan step
    logic              cur_match, cur_free, cur_old;
    logic              found_n, have_free_n;
    logic [SLOT_W-1:0] match_n, free_n, old_n, sel_slot;
    logic              ptr_last;
    assign ptr_last    = ptr_reg == SLOT_W'(SLOTS - 1);
    assign cur_match   = slot_valid_reg[ptr_reg] && (slot_fnum_reg[ptr_reg] == fnum_reg);
    assign cur_free    = !slot_valid_reg[ptr_reg];
    assign cur_old     = (ptr_reg == '0) || age_over;
    assign found_n     = found_reg || cur_match;
    assign match_n     = (!found_reg && cur_match) ? ptr_reg : match_reg;
    assign have_free_n = have_free_reg || cur_free;
    assign free_n      = (!have_free_reg && cur_free) ? ptr_reg : free_idx_reg;
    assign old_n       = cur_old ? ptr_reg : old_idx_reg;
    assign sel_slot    = found_n ? match_n : (have_free_n ? free_n : old_n);

    // bitmap memory
    logic [ROWS_W-1:0]          piece_row, mem_row;
    logic [MEM_AW-1:0]          mem_addr;
    logic                       mem_we;
    logic [frt_pkg::ROW_W-1:0]  mem_wdata, mem_rdata, piece_mask;
    logic                       seen_bit;
    assign piece_row  = ROWS_W'(pidx_reg >> 5);
    assign mem_row    = (state_reg == S_CLEAR) ? clr_row_reg : piece_row;
    assign mem_addr   = MEM_AW'(32'(ptr_reg) * ROWS + 32'(mem_row));
    assign piece_mask = frt_pkg::ROW_W'(1) << pidx_reg[4:0];
    assign seen_bit   = (mem_rdata & piece_mask) != '0;
    assign mem_we     = (state_reg == S_CLEAR) || ((state_reg == S_UPD) && !seen_bit);
    assign mem_wdata  = (state_reg == S_CLEAR) ? '0 : (mem_rdata | piece_mask);

    frt_seen_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_seen (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    logic [ROWS_W-1:0] clr_last;
    logic              attr_bad, range_bad, complete;
    logic [15:0]       got_new;
    assign clr_last  = ROWS_W'((ptot_reg - 16'd1) >> 5);
    assign attr_bad  = (slot_ptot_reg[ptr_reg] != ptot_reg)
                    || (32'(slot_bytes_reg[ptr_reg]) != tot_reg)
                    || (slot_flags_reg[ptr_reg] != flags_reg)
                    || (slot_time_reg[ptr_reg] != ctime_reg);
    assign range_bad = (33'(prod_reg) + 33'(pay_reg)) > 33'(slot_bytes_reg[ptr_reg]);
    assign got_new   = seen_bit ? slot_got_reg[ptr_reg] : slot_got_reg[ptr_reg] + 16'd1;
    assign complete  = got_new == slot_ptot_reg[ptr_reg];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_MUL1;
            S_MUL1:  state_next = S_CHECK;
            S_CHECK: state_next = (bad_hdr || stale_id) ? S_EMIT : S_SCAN;
            S_SCAN:  if (ptr_last) state_next = found_n ? S_ATTR : S_ALLOC;
            S_ALLOC: state_next = S_CLEAR;
            S_CLEAR: if (clr_row_reg == clr_last) state_next = S_MUL2;
            S_ATTR:  state_next = attr_bad ? S_EMIT : S_MUL2;
            S_MUL2:  state_next = S_RANGE;
            S_RANGE: state_next = range_bad ? S_EMIT : S_UPD;
            S_UPD:   state_next = complete ? S_PURGE : S_AGE;
            S_PURGE: if (ptr_last) state_next = S_EMIT;
            S_AGE:   if (ptr_last) state_next = S_EMIT;
            S_EMIT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            timeout_reg   <= frt_pkg::DEF_TIMEOUT;
            max_frame_reg <= frt_pkg::FRAME_LIMIT;
            last_num_reg  <= '0;
            any_reg       <= 1'b0;
            drop_reg      <= '0;
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == frt_pkg::REG_STALE_TIMEOUT)
                begin
                    timeout_reg <= cfg_data;
                end
                else
                begin
                    max_frame_reg <= cfg_data[22:0];
                end
            end
            case (state_reg)
                S_SCAN:
                begin
                    if (ptr_last && !found_n && !have_free_n)
                    begin
                        slot_valid_reg[sel_slot] <= 1'b0;
                        drop_reg <= frt_pkg::sat_inc(drop_reg);
                    end
                end
                S_ALLOC:  slot_valid_reg[ptr_reg] <= 1'b1;
                S_ATTR:
                begin
                    if (attr_bad)
                    begin
                        slot_valid_reg[ptr_reg] <= 1'b0;
                        drop_reg <= frt_pkg::sat_inc(drop_reg);
                    end
                end
                S_UPD:
                begin
                    if (complete)
                    begin
                        slot_valid_reg[ptr_reg] <= 1'b0;
                        last_num_reg <= fnum_reg;
                        any_reg      <= 1'b1;
                    end
                end
                S_PURGE:
                begin
                    if (slot_valid_reg[ptr_reg]
                        && !frt_pkg::is_newer(slot_fnum_reg[ptr_reg], fnum_reg))
                    begin
                        slot_valid_reg[ptr_reg] <= 1'b0;
                        drop_reg <= frt_pkg::sat_inc(drop_reg);
                    end
                end
                S_AGE:
                begin
                    if (slot_valid_reg[ptr_reg] && age_over)
                    begin
                        slot_valid_reg[ptr_reg] <= 1'b0;
                        drop_reg <= frt_pkg::sat_inc(drop_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                magic_reg  <= hdr_magic;
                ver_reg    <= hdr_version;
                flags_reg  <= hdr_flags;
                fnum_reg   <= frame_number;
                pidx_reg   <= piece_index;
                ptot_reg   <= piece_total;
                pay_reg    <= payload_bytes;
                tot_reg    <= total_bytes;
                ctime_reg  <= capture_time;
                dgram_reg  <= datagram_bytes;
                now_reg    <= now_us;
                ptr_reg    <= '0;
                found_reg  <= 1'b0;
                have_free_reg <= 1'b0;
                match_reg  <= '0;
                free_idx_reg <= '0;
                old_idx_reg  <= '0;
                best_reg   <= '0;
                status_reg <= frt_pkg::ST_STORED;
                wr_reg     <= 1'b0;
                wslot_reg  <= '0;
                woff_reg   <= '0;
                dnum_reg   <= '0;
                dflags_reg <= '0;
                dtime_reg  <= '0;
                dbytes_reg <= '0;
            end
            S_MUL1:  prod_reg <= mul_p;
            S_CHECK:
            begin
                if (bad_hdr)
                begin
                    status_reg <= frt_pkg::ST_BAD_HDR;
                end
                else if (stale_id)
                begin
                    status_reg <= frt_pkg::ST_STALE_ID;
                end
            end
            S_SCAN:
            begin
                found_reg     <= found_n;
                match_reg     <= match_n;
                have_free_reg <= have_free_n;
                free_idx_reg  <= free_n;
                old_idx_reg   <= old_n;
                if (cur_old)
                begin
                    best_reg <= age;
                end
                ptr_reg <= ptr_last ? sel_slot : ptr_reg + SLOT_W'(1);
            end
            S_ALLOC:
            begin
                slot_fnum_reg[ptr_reg]  <= fnum_reg;
                slot_flags_reg[ptr_reg] <= flags_reg;
                slot_ptot_reg[ptr_reg]  <= ptot_reg;
                slot_bytes_reg[ptr_reg] <= tot_reg[22:0];
                slot_time_reg[ptr_reg]  <= ctime_reg;
                slot_lu_reg[ptr_reg]    <= '0;
                slot_got_reg[ptr_reg]   <= '0;
                clr_row_reg <= '0;
            end
            S_CLEAR: clr_row_reg <= clr_row_reg + ROWS_W'(1);
            S_ATTR:  if (attr_bad) status_reg <= frt_pkg::ST_MISMATCH;
            S_MUL2:  prod_reg <= mul_p;
            S_RANGE: if (range_bad) status_reg <= frt_pkg::ST_RANGE;
            S_UPD:
            begin
                slot_got_reg[ptr_reg] <= got_new;
                slot_lu_reg[ptr_reg]  <= now_reg;
                if (!seen_bit)
                begin
                    wr_reg    <= 1'b1;
                    wslot_reg <= ptr_reg;
                    woff_reg  <= prod_reg[21:0];
                end
                if (complete)
                begin
                    status_reg <= frt_pkg::ST_COMPLETE;
                    dnum_reg   <= fnum_reg;
                    dflags_reg <= slot_flags_reg[ptr_reg];
                    dtime_reg  <= slot_time_reg[ptr_reg];
                    dbytes_reg <= slot_bytes_reg[ptr_reg];
                end
                else
                begin
                    status_reg <= seen_bit ? frt_pkg::ST_DUP : frt_pkg::ST_STORED;
                end
                ptr_reg <= '0;
            end
            S_PURGE: ptr_reg <= ptr_reg + SLOT_W'(1);
            S_AGE:   ptr_reg <= ptr_reg + SLOT_W'(1);
            default: ;
        endcase
    end

    assign busy              = state_reg != S_IDLE;
    assign result_valid      = state_reg == S_EMIT;
    assign status            = status_reg;
    assign write_payload     = wr_reg;
    assign write_slot        = wslot_reg;
    assign write_offset      = woff_reg;
    assign done_frame_number = dnum_reg;
    assign done_flags        = dflags_reg;
    assign done_time         = dtime_reg;
    assign done_bytes        = dbytes_reg;
    assign dropped_total     = drop_reg;

    `FRT_ASSERT_NEXT(a_pulse, clk, rst_n, result_valid, !result_valid && !busy, "result not a single pulse")
    `FRT_ASSERT_NEXT(a_take, clk, rst_n, start && !busy, busy, "transaction not taken")
    `FRT_ASSERT_SAME(a_write_status, clk, rst_n, result_valid && write_payload, status == frt_pkg::ST_STORED || status == frt_pkg::ST_COMPLETE, "write with wrong status")
    `FRT_ASSERT_SAME(a_done_zero, clk, rst_n, result_valid && status != frt_pkg::ST_COMPLETE, done_frame_number == 32'd0 && done_bytes == 23'd0, "done fields without completion")

endmodule

`default_nettype wire

// File: verif/fragment_reassembly_tracker_tb.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker testbench
// Drives parsed datagram headers through the command port. A directed table
// covers header rejects, stale ids, duplicates, attribute mismatches, range
// errors and completion. Random phases then run a pool of frames in flight
// under several register settings. Every result is checked field by field
// against an in-bench slot tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembly_tracker_tb;

    localparam int unsigned PAYLOAD_MAX = frt_pkg::DEF_MAX_PAYLOAD;
    localparam int unsigned PIECES_MAX  = frt_pkg::DEF_MAX_PIECES;
    localparam int unsigned NSLOT       = frt_pkg::DEF_SLOTS;
    localparam int unsigned POOL        = 10;
    localparam int unsigned SETTLE      = 200;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] flags;
        logic [31:0] fnum;
        logic [15:0] pidx;
        logic [15:0] ptot;
        logic [15:0] pay;
        logic [31:0] tot;
        logic [63:0] ctime;
        logic [15:0] dgram;
        logic [63:0] now;
    } hdr_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        wr;
        logic [2:0]  wslot;
        logic [21:0] woff;
        logic [31:0] dnum;
        logic [15:0] dflags;
        logic [63:0] dtime;
        logic [22:0] dbytes;
        logic [31:0] drops;
    } res_t;

    typedef struct packed {
        logic [31:0] fnum;
        logic [15:0] flags;
        logic [15:0] ptot;
        logic [31:0] tot;
        logic [63:0] ctime;
    } frame_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    hdr_t        drv;
    logic        result_valid;
    logic [2:0]  status;
    logic        write_payload;
    logic [2:0]  write_slot;
    logic [21:0] write_offset;
    logic [31:0] done_frame_number;
    logic [15:0] done_flags;
    logic [63:0] done_time;
    logic [22:0] done_bytes;
    logic [31:0] dropped_total;

    fragment_reassembly_tracker uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .start             (start),
        .busy              (busy),
        .hdr_magic         (drv.magic),
        .hdr_version       (drv.version),
        .hdr_flags         (drv.flags),
        .frame_number      (drv.fnum),
        .piece_index       (drv.pidx),
        .piece_total       (drv.ptot),
        .payload_bytes     (drv.pay),
        .total_bytes       (drv.tot),
        .capture_time      (drv.ctime),
        .datagram_bytes    (drv.dgram),
        .now_us            (drv.now),
        .result_valid      (result_valid),
        .status            (status),
        .write_payload     (write_payload),
        .write_slot        (write_slot),
        .write_offset      (write_offset),
        .done_frame_number (done_frame_number),
        .done_flags        (done_flags),
        .done_time         (done_time),
        .done_bytes        (done_bytes),
        .dropped_total     (dropped_total)
    );

    // tracker state
    bit                    trk_valid [NSLOT];
    logic [31:0]           trk_fnum [NSLOT];
    logic [15:0]           trk_flags [NSLOT];
    logic [15:0]           trk_ptot [NSLOT];
    logic [22:0]           trk_bytes [NSLOT];
    logic [63:0]           trk_time [NSLOT];
    logic [63:0]           trk_touch [NSLOT];
    logic [15:0]           trk_got [NSLOT];
    logic [PIECES_MAX-1:0] trk_seen [NSLOT];
    logic [31:0]           last_done;
    bit                    any_done;
    logic [31:0]           drop_cnt;
    logic [31:0]           stale_us;
    logic [22:0]           frame_cap;

    res_t        pending_results[$];
    int          errors;
    int          mismatches;
    int          accepted;
    int          status_seen [8];
    bit          burst;

    hdr_t        dir_hdr[$];
    bit          dir_has[$];
    logic [2:0]  dir_st[$];

    frame_t      pool [POOL];
    logic [31:0] next_fnum;
    logic [63:0] clock_us;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit newer(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic void bump_drop();
        if (drop_cnt != 32'hFFFF_FFFF)
            drop_cnt = drop_cnt + 32'd1;
    endfunction

    function automatic res_t assemble(input hdr_t h);
        res_t        r;
        logic [22:0] lim;
        logic [63:0] off;
        logic [63:0] age;
        logic [63:0] best;
        int          s;
        bit          hit;
        bit          room;
        r = '0;
        lim = (frame_cap < frt_pkg::FRAME_LIMIT) ? frame_cap : frt_pkg::FRAME_LIMIT;
        if (h.magic != frt_pkg::HDR_MAGIC || h.version != frt_pkg::HDR_VERSION ||
            h.ptot == 16'd0 ||
            h.ptot > PIECES_MAX || h.pidx >= h.ptot || h.pay > PAYLOAD_MAX ||
            {1'b0, h.dgram} != frt_pkg::HDR_BYTES + {1'b0, h.pay} || h.tot == 32'd0 ||
            h.tot > {9'd0, lim} ||
            (64'(h.ptot) - 64'd1) * PAYLOAD_MAX >= 64'(h.tot))
        begin
            r.status = frt_pkg::ST_BAD_HDR;
            r.drops = drop_cnt;
            return r;
        end
        if (any_done && !newer(h.fnum, last_done))
        begin
            r.status = frt_pkg::ST_STALE_ID;
            r.drops = drop_cnt;
            return r;
        end
        s = 0;
        hit = 1'b0;
        for (int k = 0; k < NSLOT; k++)
            if (!hit && trk_valid[k] && trk_fnum[k] == h.fnum)
            begin
                s = k;
                hit = 1'b1;
            end
        if (!hit)
        begin
            room = 1'b0;
            for (int k = 0; k < NSLOT; k++)
                if (!room && !trk_valid[k])
                begin
                    s = k;
                    room = 1'b1;
                end
            if (!room)
            begin
                best = '0;
                s = 0;
                for (int k = 0; k < NSLOT; k++)
                begin
                    age = h.now - trk_touch[k];
                    if (k == 0 || age > best)
                    begin
                        best = age;
                        s = k;
                    end
                end
                trk_valid[s] = 1'b0;
                bump_drop();
            end
            trk_valid[s] = 1'b1;
            trk_fnum[s]  = h.fnum;
            trk_flags[s] = h.flags;
            trk_ptot[s]  = h.ptot;
            trk_bytes[s] = h.tot[22:0];
            trk_time[s]  = h.ctime;
            trk_touch[s] = '0;
            trk_got[s]   = '0;
            trk_seen[s]  = '0;
        end
        if (trk_ptot[s] != h.ptot || 32'(trk_bytes[s]) != h.tot ||
            trk_flags[s] != h.flags || trk_time[s] != h.ctime)
        begin
            trk_valid[s] = 1'b0;
            bump_drop();
            r.status = frt_pkg::ST_MISMATCH;
            r.drops = drop_cnt;
            return r;
        end
        off = 64'(h.pidx) * PAYLOAD_MAX;
        if (off + 64'(h.pay) > 64'(trk_bytes[s]))
        begin
            r.status = frt_pkg::ST_RANGE;
            r.drops = drop_cnt;
            return r;
        end
        if (!trk_seen[s][h.pidx])
        begin
            trk_seen[s][h.pidx] = 1'b1;
            trk_got[s] = trk_got[s] + 16'd1;
            r.wr = 1'b1;
            r.wslot = s[2:0];
            r.woff = off[21:0];
            r.status = frt_pkg::ST_STORED;
        end
        else
            r.status = frt_pkg::ST_DUP;
        trk_touch[s] = h.now;
        if (trk_got[s] == trk_ptot[s])
        begin
            r.status = frt_pkg::ST_COMPLETE;
            r.dnum   = h.fnum;
            r.dflags = trk_flags[s];
            r.dtime  = trk_time[s];
            r.dbytes = trk_bytes[s];
            trk_valid[s] = 1'b0;
            last_done = h.fnum;
            any_done = 1'b1;
            for (int k = 0; k < NSLOT; k++)
                if (trk_valid[k] && !newer(trk_fnum[k], h.fnum))
                begin
                    trk_valid[k] = 1'b0;
                    bump_drop();
                end
            r.drops = drop_cnt;
            return r;
        end
        for (int k = 0; k < NSLOT; k++)
            if (trk_valid[k] && h.now - trk_touch[k] > 64'(stale_us))
            begin
                trk_valid[k] = 1'b0;
                bump_drop();
            end
        r.drops = drop_cnt;
        return r;
    endfunction

    task automatic send_header(input hdr_t h, input bit has_st, input logic [2:0] typed_st,
                               output logic [2:0] got_st);
        res_t r;
        int   gap;
        @(negedge clk);
        drv <= h;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        r = assemble(h);
        if (has_st)
            r.status = typed_st;
        got_st = r.status;
        pending_results.push_back(r);
        accepted++;
        status_seen[r.status]++;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_all();
        int waited;
        @(negedge clk);
        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == frt_pkg::REG_STALE_TIMEOUT)
            stale_us = val;
        else
            frame_cap = val[22:0];
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("unexpected transaction: status %0d", status);
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("status", 64'(e.status), 64'(status));
                check_field("write_payload", 64'(e.wr), 64'(write_payload));
                check_field("write_slot", 64'(e.wslot), 64'(write_slot));
                check_field("write_offset", 64'(e.woff), 64'(write_offset));
                check_field("done_frame_number", 64'(e.dnum), 64'(done_frame_number));
                check_field("done_flags", 64'(e.dflags), 64'(done_flags));
                check_field("done_time", e.dtime, done_time);
                check_field("done_bytes", 64'(e.dbytes), 64'(done_bytes));
                check_field("dropped_total", 64'(e.drops), 64'(dropped_total));
            end
        end
    end

    function automatic hdr_t good_hdr(input logic [31:0] fn, input int pidx, input int ptot,
                                      input int pay, input int tot, input logic [63:0] now);
        hdr_t h;
        h.magic   = frt_pkg::HDR_MAGIC;
        h.version = frt_pkg::HDR_VERSION;
        h.flags   = '0;
        h.fnum    = fn;
        h.pidx    = pidx[15:0];
        h.ptot    = ptot[15:0];
        h.pay     = pay[15:0];
        h.tot     = tot;
        h.ctime   = '0;
        h.dgram   = 16'(32 + pay);
        h.now     = now;
        return h;
    endfunction

    function automatic void add_row(input hdr_t h, input bit has, input logic [2:0] st);
        dir_hdr.push_back(h);
        dir_has.push_back(has);
        dir_st.push_back(st);
    endfunction

    function automatic frame_t fresh_frame();
        frame_t f;
        int     pick;
        f.fnum  = next_fnum;
        next_fnum = next_fnum + $urandom_range(1, 3);
        if ($urandom_range(0, 99) == 0)
            next_fnum = next_fnum + 32'h7FFF_FFF0;
        f.flags = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 80)
            f.ptot = 16'($urandom_range(1, 4));
        else if (pick < 95)
            f.ptot = 16'($urandom_range(5, 40));
        else
            f.ptot = 16'($urandom_range(100, 3178));
        f.tot = (f.ptot - 1) * PAYLOAD_MAX + $urandom_range(1, PAYLOAD_MAX);
        if (f.tot > 32'd4194304)
            f.tot = 32'd4194304;
        f.ctime = {$urandom, $urandom};
        return f;
    endfunction

    function automatic hdr_t pool_item(input int k);
        hdr_t   h;
        frame_t f;
        int     pidx;
        int     pay;
        f = pool[k];
        pidx = $urandom_range(0, f.ptot - 1);
        pay = (pidx == f.ptot - 1) ? f.tot - (f.ptot - 1) * PAYLOAD_MAX : PAYLOAD_MAX;
        if ($urandom_range(0, 19) == 0)
            pay = $urandom_range(0, PAYLOAD_MAX);
        h = good_hdr(f.fnum, pidx, f.ptot, pay, f.tot, clock_us);
        h.flags = f.flags;
        h.ctime = f.ctime;
        return h;
    endfunction

    task automatic random_phase(input int count);
        hdr_t       h;
        logic [2:0] st;
        int         k;
        int         pick;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (n == count / 2)
                drain_all();
            clock_us = clock_us + $urandom_range(0, 3000);
            if ($urandom_range(0, 39) == 0)
                clock_us = clock_us + 64'd400000;
            k = $urandom_range(0, POOL - 1);
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
                h.now = clock_us;
                if ($urandom_range(0, 1))
                    h.magic = frt_pkg::HDR_MAGIC;
                if ($urandom_range(0, 1))
                    h.version = frt_pkg::HDR_VERSION;
            end
            else
            begin
                h = pool_item(k);
                if (pick < 15)
                begin
                    if ($urandom_range(0, 1))
                        h.flags = h.flags ^ 16'h0001;
                    else
                        h.ctime = h.ctime + 64'd1;
                end
            end
            send_header(h, 1'b0, frt_pkg::ST_STORED, st);
            if (pick >= 10 && (st == frt_pkg::ST_COMPLETE || st == frt_pkg::ST_STALE_ID
                || st == frt_pkg::ST_MISMATCH || $urandom_range(0, 29) == 0))
                pool[k] = fresh_frame();
        end
        drain_all();
    endtask

    initial
    begin
        logic [2:0] st;
        hdr_t       h;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = frt_pkg::REG_STALE_TIMEOUT;
        cfg_data = '0;
        start = 1'b0;
        drv = '0;
        errors = 0;
        mismatches = 0;
        accepted = 0;
        burst = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (trk_valid[i])
        begin
            trk_valid[i] = 1'b0;
            trk_fnum[i] = '0;
            trk_flags[i] = '0;
            trk_ptot[i] = '0;
            trk_bytes[i] = '0;
            trk_time[i] = '0;
            trk_touch[i] = '0;
            trk_got[i] = '0;
            trk_seen[i] = '0;
        end
        last_done = '0;
        any_done = 1'b0;
        drop_cnt = '0;
        stale_us = frt_pkg::DEF_TIMEOUT;
        frame_cap = frt_pkg::FRAME_LIMIT;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        h = good_hdr(1, 0, 1, 10, 10, 100); h.magic = ~frt_pkg::HDR_MAGIC;
        add_row(h, 1, frt_pkg::ST_BAD_HDR);
        h = good_hdr(1, 0, 1, 10, 10, 100); h.version = 16'hFFFF;
        add_row(h, 1, frt_pkg::ST_BAD_HDR);
        add_row(good_hdr(1, 0, 0, 10, 10, 100), 1, frt_pkg::ST_BAD_HDR);
        add_row(good_hdr(1, 0, 4097, 10, 10, 100), 1, frt_pkg::ST_BAD_HDR);
        add_row(good_hdr(1, 2, 2, 10, 2000, 100), 1, frt_pkg::ST_BAD_HDR);
        add_row(good_hdr(1, 0, 1, 1321, 1321, 100), 1, frt_pkg::ST_BAD_HDR);
        h = good_hdr(1, 0, 1, 10, 10, 100); h.dgram = 16'd41;
        add_row(h, 1, frt_pkg::ST_BAD_HDR);
        add_row(good_hdr(1, 0, 1, 0, 0, 100), 1, frt_pkg::ST_BAD_HDR);
        add_row(good_hdr(1, 0, 1, 10, 4194305, 100), 1, frt_pkg::ST_BAD_HDR);
        add_row(good_hdr(1, 0, 2, 10, 1320, 100), 1, frt_pkg::ST_BAD_HDR);
        add_row(good_hdr(10, 0, 1, 100, 100, 100), 1, frt_pkg::ST_COMPLETE);
        add_row(good_hdr(10, 0, 1, 100, 100, 200), 1, frt_pkg::ST_STALE_ID);
        add_row(good_hdr(5, 0, 1, 100, 100, 200), 1, frt_pkg::ST_STALE_ID);
        add_row(good_hdr(11, 0, 2, 1320, 2000, 300), 1, frt_pkg::ST_STORED);
        add_row(good_hdr(11, 0, 2, 1320, 2000, 400), 1, frt_pkg::ST_DUP);
        h = good_hdr(11, 1, 2, 680, 2000, 500); h.flags = 16'h0001;
        add_row(h, 1, frt_pkg::ST_MISMATCH);
        add_row(good_hdr(12, 1, 2, 1320, 2000, 600), 1, frt_pkg::ST_RANGE);
        add_row(good_hdr(12, 0, 2, 1320, 2000, 700), 1, frt_pkg::ST_STORED);
        add_row(good_hdr(13, 3177, 4096, 664, 4194304, 800), 0, frt_pkg::ST_STORED);
        add_row(good_hdr(13, 4095, 4096, 1320, 4194304, 900), 1, frt_pkg::ST_BAD_HDR);
        add_row(good_hdr(12, 1, 2, 680, 2000, 1000), 1, frt_pkg::ST_COMPLETE);
        add_row(good_hdr(14, 0, 2, 1320, 2000, 1000000), 0, frt_pkg::ST_STORED);
        h = good_hdr(32'hFFFF_FFFF, 0, 1, 1, 1, 1000100);
        add_row(h, 1, frt_pkg::ST_STALE_ID);
        h = good_hdr(32'h8000_000B, 0, 1, 1320, 1320, 1000200);
        h.flags = 16'hFFFF;
        h.ctime = '1;
        add_row(h, 0, frt_pkg::ST_STORED);
        foreach (dir_hdr[i])
            send_header(dir_hdr[i], dir_has[i], dir_st[i], st);
        drain_all();

        next_fnum = $urandom;
        clock_us = {$urandom, $urandom};
        foreach (pool[i])
            pool[i] = fresh_frame();

        random_phase(260);
        write_reg(frt_pkg::REG_STALE_TIMEOUT, 32'd0);
        write_reg(frt_pkg::REG_MAX_FRAME, 32'hFFFF_FFFF);
        random_phase(140);
        write_reg(frt_pkg::REG_STALE_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(frt_pkg::REG_MAX_FRAME, 32'd1);
        random_phase(40);
        write_reg(frt_pkg::REG_STALE_TIMEOUT, 32'd5000);
        write_reg(frt_pkg::REG_MAX_FRAME, 32'd100000);
        random_phase(140);
        write_reg(frt_pkg::REG_STALE_TIMEOUT, frt_pkg::DEF_TIMEOUT);
        write_reg(frt_pkg::REG_MAX_FRAME, 32'(frt_pkg::FRAME_LIMIT));
        random_phase(170);

        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0d expected transactions never arrived", pending_results.size());
        end
        $display("%0d headers sent over five register settings; stored %0d, dup %0d,",
                 accepted, status_seen[frt_pkg::ST_STORED], status_seen[frt_pkg::ST_DUP]);
        $display("complete %0d, bad %0d, stale %0d, mismatch %0d, range %0d; %0d errors",
                 status_seen[frt_pkg::ST_COMPLETE], status_seen[frt_pkg::ST_BAD_HDR],
                 status_seen[frt_pkg::ST_STALE_ID], status_seen[frt_pkg::ST_MISMATCH],
                 status_seen[frt_pkg::ST_RANGE], errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/frt_pkg.sv
rtl/frt_seen_mem.sv
rtl/frt_age_cmp.sv
rtl/fragment_reassembly_tracker.sv
verif/fragment_reassembly_tracker_tb.sv
